@@ design/fpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fpe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int PIDX_W        = 3;
  localparam logic [PIDX_W-1:0] PLANE_LAST = 3'd5;

  localparam logic signed [ELEM_W-1:0] COEF_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] COEF_MIN = 32'sh8000_0000;

  // magnitude of a signed 32-bit value; -2^31 maps to 2^31
  function automatic logic [ELEM_W-1:0] mag32(input logic signed [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] r;
    r = v[ELEM_W-1] ? ELEM_W'(-v) : ELEM_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/frustum_plane_extract.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_element_value (Q16.16)
// out_     output     out_valid / out_ready  out_plane_index, out_coef_x/y/z/w,
//                                            out_degenerate, out_last_plane
//
// Each element item is accepted while the sequencer is idle; the sixteenth
// starts a plane run that holds in_ready low. A plane run reads and sums
// the columns, squares and accumulates, sets up, takes a bit-serial root,
// divides each coefficient and emits; degenerate planes skip root and divide.
// Reset (rst_n, synchronous) clears the element count and control only.
// A stalled out_ready parks the run in emit until the output register frees.
module frustum_plane_extract #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire signed [31:0]         in_element_value,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [2:0]                out_plane_index,
  output logic signed [31:0]        out_coef_x,
  output logic signed [31:0]        out_coef_y,
  output logic signed [31:0]        out_coef_z,
  output logic signed [31:0]        out_coef_w,
  output logic                      out_degenerate,
  output logic                      out_last_plane
);
  import fpe_pkg::*;

  // dividend width: magnitude << FRAC_BITS plus half the length
  localparam int NW  = ELEM_W + 1 + FRAC_BITS;
  localparam int ITW = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_CMB  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_SQS  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIVI = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DFIN = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0]               state_r;
  logic [3:0]               cnt_r;       // elements loaded
  logic [PIDX_W-1:0]        plane_r;
  logic [1:0]               j_r;         // column / coefficient index
  logic [ITW-1:0]           it_r;        // root / divide step count

  // matrix store, one write and one registered read port
  logic signed [ELEM_W-1:0] mem [0:15];
  logic signed [ELEM_W-1:0] rd_data_r;
  logic [3:0]               rd_addr;

  logic signed [ELEM_W-1:0] a_r;
  logic signed [ELEM_W-1:0] c_r    [0:3];
  logic signed [ELEM_W-1:0] coef_r [0:3];
  logic [63:0]              prod_r;
  logic [63:0]              s2_r;
  logic                     degen_r;

  // shared root unit
  logic [63:0]              op_r;
  logic [34:0]              srem_r;
  logic [ELEM_W-1:0]        root_r;
  // shared divider
  logic [NW-1:0]            num_r;
  logic [ELEM_W:0]          drem_r;

  logic                     out_valid_r;
  logic                     in_acc;
  logic                     emit_go;

  logic signed [ELEM_W:0]   sum;
  logic signed [ELEM_W-1:0] sum_sat;
  logic [ELEM_W-1:0]        cmag;
  logic [34:0]              srem_sh;
  logic [34:0]              strial;
  logic [ELEM_W:0]          drem_sh;
  logic signed [ELEM_W-1:0] q_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    unique case (state_r)
      S_RB:    rd_addr = {j_r, plane_r[2:1]};
      default: rd_addr = {j_r, 2'b11};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[cnt_r] <= in_element_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // m[j][3] +/- m[j][r], saturated
  always_comb begin
    if (plane_r[0]) begin
      sum = {a_r[ELEM_W-1], a_r} - {rd_data_r[ELEM_W-1], rd_data_r};
    end else begin
      sum = {a_r[ELEM_W-1], a_r} + {rd_data_r[ELEM_W-1], rd_data_r};
    end
    if (sum[ELEM_W] != sum[ELEM_W-1]) begin
      sum_sat = sum[ELEM_W] ? COEF_MIN : COEF_MAX;
    end else begin
      sum_sat = sum[ELEM_W-1:0];
    end
  end

  assign cmag    = mag32(c_r[j_r]);
  assign srem_sh = {srem_r[32:0], op_r[63:62]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r[ELEM_W-1:0], num_r[NW-1]};

  // round-to-nearest quotient, signed and saturated
  always_comb begin
    if (c_r[j_r][ELEM_W-1]) begin
      if (num_r > NW'(64'h8000_0000)) begin
        q_sat = COEF_MIN;
      end else begin
        q_sat = ELEM_W'(-num_r[ELEM_W-1:0]);
      end
    end else begin
      if (num_r > NW'(64'h7fff_ffff)) begin
        q_sat = COEF_MAX;
      end else begin
        q_sat = num_r[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      plane_r     <= '0;
      j_r         <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: loaded on emit, cleared when taken
      out_valid_r <= emit_go || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == 4'd15) begin
              plane_r <= '0;
              j_r     <= '0;
              state_r <= S_RA;
            end
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          a_r     <= rd_data_r;
          state_r <= S_CMB;
        end
        S_CMB: begin
          c_r[j_r] <= sum_sat;
          j_r      <= j_r + 2'd1;
          if (j_r == 2'd3) begin
            s2_r    <= '0;
            state_r <= S_SQ;
          end else begin
            state_r <= S_RA;
          end
        end
        S_SQ: begin
          prod_r  <= cmag * cmag;
          state_r <= S_ACC;
        end
        S_ACC: begin
          s2_r <= s2_r + prod_r;
          if (j_r == 2'd2) begin
            j_r     <= '0;
            state_r <= S_SQS;
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_SQ;
          end
        end
        S_SQS: begin
          op_r   <= s2_r;
          srem_r <= '0;
          root_r <= '0;
          it_r   <= ITW'(31);
          if (s2_r == 64'd0) begin
            degen_r <= 1'b1;
            for (int k = 0; k < 4; k++) coef_r[k] <= '0;
            state_r <= S_EMIT;
          end else begin
            degen_r <= 1'b0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          op_r <= {op_r[61:0], 2'b00};
          if (srem_sh >= strial) begin
            srem_r <= srem_sh - strial;
            root_r <= {root_r[ELEM_W-2:0], 1'b1};
          end else begin
            srem_r <= srem_sh;
            root_r <= {root_r[ELEM_W-2:0], 1'b0};
          end
          it_r <= it_r - ITW'(1);
          if (it_r == '0) begin
            state_r <= S_DIVI;
          end
        end
        S_DIVI: begin
          num_r   <= (NW'(cmag) << FRAC_BITS) + NW'(root_r >> 1);
          drem_r  <= '0;
          it_r    <= ITW'(NW - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (drem_sh >= {1'b0, root_r}) begin
            drem_r <= drem_sh - {1'b0, root_r};
            num_r  <= {num_r[NW-2:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            num_r  <= {num_r[NW-2:0], 1'b0};
          end
          it_r <= it_r - ITW'(1);
          if (it_r == '0) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          coef_r[j_r] <= q_sat;
          j_r         <= j_r + 2'd1;
          state_r     <= (j_r == 2'd3) ? S_EMIT : S_DIVI;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_plane_index <= plane_r;
            out_coef_x      <= coef_r[0];
            out_coef_y      <= coef_r[1];
            out_coef_z      <= coef_r[2];
            out_coef_w      <= coef_r[3];
            out_degenerate  <= degen_r;
            out_last_plane  <= (plane_r == PLANE_LAST);
            j_r             <= '0;
            if (plane_r == PLANE_LAST) begin
              state_r <= S_IDLE;
            end else begin
              plane_r <= plane_r + PIDX_W'(1);
              state_r <= S_RA;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a degenerate plane carries all-zero coefficients
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_coef_x == 0 && out_coef_y == 0 &&
      out_coef_z == 0 && out_coef_w == 0)
    else $error("degenerate plane with nonzero coefficients");

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_plane_index <= PLANE_LAST)
    else $error("plane index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_plane == (out_plane_index == PLANE_LAST)))
    else $error("last_plane flag mismatch");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cnt_r == 4'd15 |=> !in_ready && cnt_r == 4'd0)
    else $error("sixteenth item did not start a plane run");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import fpe_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [31:0] in_element_value = '0;
  logic out_ready = 1'b0;
  wire in_ready;
  wire out_valid;
  wire [2:0] out_plane_index;
  wire signed [31:0] out_coef_x, out_coef_y, out_coef_z, out_coef_w;
  wire out_degenerate, out_last_plane;

  frustum_plane_extract uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_element_value(in_element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_plane_index(out_plane_index), .out_coef_x(out_coef_x), .out_coef_y(out_coef_y),
    .out_coef_z(out_coef_z), .out_coef_w(out_coef_w),
    .out_degenerate(out_degenerate), .out_last_plane(out_last_plane)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0] pidx;
    logic signed [31:0] cx, cy, cz, cw;
    logic degen;
    logic last;
  } plane_t;

  // predictor state: loaded matrix and load counter
  logic signed [31:0] mat [16];
  logic [3:0] load_cnt;
  plane_t planes_due [$];

  int errors = 0;
  int cycle_cnt = 0;
  int fed_cnt = 0;
  bit quiet = 1'b0;      // final stretch: no idling
  bit long_hold = 1'b0;  // receiver hold-off request
  bit stim_done = 1'b0;

  localparam int LIMIT = 2_000_000;

  // floor sqrt of a 66-bit sum of squares
  function automatic logic [63:0] root_floor(input logic [65:0] v);
    logic [65:0] r, b;
    r = '0;
    b = 66'd1 << 64;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // round-half-away divide of c*2^16 by len, saturated
  function automatic logic signed [31:0] scale_coef(input logic signed [32:0] c,
                                                     input logic [63:0] len);
    logic [32:0] m;
    logic [95:0] q;
    m = c[32] ? -c : c;
    q = ({63'd0, m} << FRAC_BITS_DEF) + (len >> 1);
    q = q / len;
    if (c[32]) return (q > 96'h8000_0000) ? COEF_MIN : -$signed(q[31:0]);
    return (q > 96'h7fff_ffff) ? COEF_MAX : q[31:0];
  endfunction

  function automatic logic signed [32:0] clip33(input logic signed [33:0] v);
    if (v > 34'sh0_7fff_ffff) return 33'sh0_7fff_ffff;
    if (v < -34'sh0_8000_0000) return -33'sh0_8000_0000;
    return v[32:0];
  endfunction

  task automatic predict_load(input logic signed [31:0] v);
    logic signed [32:0] c [4];
    logic [65:0] s2;
    logic [63:0] len;
    plane_t pl;
    int r;
    mat[load_cnt] = v;
    load_cnt = load_cnt + 4'd1;
    if (load_cnt != 0) return;
    for (int p = 0; p < 6; p++) begin
      r = p >> 1;
      for (int j = 0; j < 4; j++) begin
        if (p & 1) c[j] = clip33(34'(mat[4*j+3]) - 34'(mat[4*j+r]));
        else c[j] = clip33(34'(mat[4*j+3]) + 34'(mat[4*j+r]));
      end
      s2 = '0;
      for (int j = 0; j < 3; j++) s2 = s2 + 66'(66'(c[j]) * 66'(c[j]));
      pl.pidx = p[2:0];
      pl.last = (p == 5);
      if (s2 == 0) begin
        pl.cx = '0; pl.cy = '0; pl.cz = '0; pl.cw = '0; pl.degen = 1'b1;
      end else begin
        len = root_floor(s2);
        pl.cx = scale_coef(c[0], len);
        pl.cy = scale_coef(c[1], len);
        pl.cz = scale_coef(c[2], len);
        pl.cw = scale_coef(c[3], len);
        pl.degen = 1'b0;
      end
      planes_due.push_back(pl);
    end
  endtask

  // checker on accepted result items
  always @(posedge clk) begin
    plane_t exp_pl, got;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_plane_index, out_coef_x, out_coef_y, out_coef_z, out_coef_w,
              out_degenerate, out_last_plane};
      if (planes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected plane item %p", got);
      end else begin
        exp_pl = planes_due.pop_front();
        if (got !== exp_pl) begin
          errors++;
          if (errors <= 10) $display("plane mismatch: expected %p got %p", exp_pl, got);
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  // one element item; valid held until accepted
  task automatic send_elem(input logic signed [31:0] v);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_load(v);
    fed_cnt++;
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (planes_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_elem(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 131072)) - 32'sd65536;
      2: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      default: return $signed($urandom_range(0, 8)) - 32'sd4;
    endcase
  endfunction

  // directed matrices: identity, all zero, extremes
  logic signed [31:0] dir_tab [3][16];

  initial begin
    int mode;
    dir_tab[0] = '{32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0,
                   0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000};
    dir_tab[1] = '{default: 32'sh0};
    dir_tab[2] = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX,
                   COEF_MIN, COEF_MAX, 1, -1, 32'sh5555_5555, 32'shaaaa_aaaa,
                   COEF_MAX, COEF_MIN, 0, COEF_MAX};
    load_cnt = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int t = 0; t < 3; t++) begin
      for (int k = 0; k < 16; k++) send_elem(dir_tab[t][k]);
      // all-zero matrix: every plane degenerate with zero coefficients
      if (t == 1) begin
        planes_due.delete();
        for (int p = 0; p < 6; p++)
          planes_due.push_back(plane_t'{p[2:0], 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                                        1'b1, p == 5});
      end
      drain_wait();
    end

    // long receiver hold-off while two matrices are offered
    long_hold = 1'b1;
    for (int k = 0; k < 16; k++) send_elem(rand_elem(1));
    for (int k = 0; k < 16; k++) send_elem(rand_elem(0));
    drain_wait();

    for (int k = 0; k < 96; k++) begin
      if (k % 16 == 0) mode = $urandom_range(0, 3);
      if (k >= 64) quiet = 1'b1;
      send_elem(rand_elem(mode));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (planes_due.size() != 0 && cycle_cnt < LIMIT) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && planes_due.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
